// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the JSON string unescaper.
package jsu_pkg;

	localparam int MAX_TEXT_LEN  = 65536;
	localparam int POS_LIMIT_INT = (MAX_TEXT_LEN - 1 > 65535) ? 65535 : MAX_TEXT_LEN - 1;
	localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);

	localparam int MAX_RESULTS = 4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_QUOTE    = 3'd1;
	localparam logic [2:0] ST_CONTROL     = 3'd2;
	localparam logic [2:0] ST_TRUNC_ESC   = 3'd3;
	localparam logic [2:0] ST_TRUNC_UNI   = 3'd4;
	localparam logic [2:0] ST_BAD_HEX     = 3'd5;
	localparam logic [2:0] ST_BAD_ESC     = 3'd6;
	localparam logic [2:0] ST_UNTERM      = 3'd7;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [15:0] error_position;
	} result_t;

	typedef struct packed {
		logic [2:0]                    count;
		result_t [MAX_RESULTS-1:0]     res;
	} burst_t;

	function automatic result_t mk_data(input logic [7:0] d);
		result_t r;
		r.kind           = KIND_DATA;
		r.data_byte      = d;
		r.status         = ST_OK;
		r.error_position = 16'd0;
		return r;
	endfunction

	function automatic result_t mk_status(input logic [2:0] s, input logic [15:0] p);
		result_t r;
		r.kind           = KIND_STATUS;
		r.data_byte      = 8'd0;
		r.status         = s;
		r.error_position = p;
		return r;
	endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
// Decode state registers and the per-byte unescape logic.
module jsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [7:0]       byte_in,
	input  logic             first_byte,
	input  logic             input_ends,
	output jsu_pkg::burst_t  burst
);

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_STR  = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_HEX  = 2'd3;

	logic [1:0]  mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] pos_q, pos_d;

	function automatic logic [15:0] sat_inc(input logic [15:0] p);
		return (p >= jsu_pkg::POS_LIMIT) ? jsu_pkg::POS_LIMIT : p + 16'd1;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "9")      r = {1'b1, 4'(b - 8'h30)};
		else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
		else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	logic [15:0] here;
	logic [15:0] cp;
	logic [4:0]  hv;
	logic [2:0]  n;
	logic [2:0]  trunc_st;

	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		acc_d     = acc_q;
		pos_d     = pos_q;
		here      = pos_q;
		n         = 3'd0;
		cp        = {acc_q[11:0], 4'd0};
		hv        = hex_value(byte_in);
		trunc_st  = jsu_pkg::ST_UNTERM;
		burst.res = '0;

		if (first_byte) begin
			hex_cnt_d = 2'd0;
			acc_d     = 16'd0;
			here      = 16'd0;
			pos_d     = sat_inc(16'd0);
			if (byte_in != "\"") begin
				mode_d       = MODE_IDLE;
				burst.res[0] = jsu_pkg::mk_status(jsu_pkg::ST_NO_QUOTE, here);
				n            = 3'd1;
			end else begin
				mode_d = MODE_STR;
			end
		end else if (mode_q != MODE_IDLE) begin
			pos_d = sat_inc(pos_q);
			unique case (mode_q)
				MODE_STR: begin
					if (byte_in == "\"") begin
						mode_d       = MODE_IDLE;
						burst.res[0] = jsu_pkg::mk_status(jsu_pkg::ST_OK, 16'd0);
						n            = 3'd1;
					end else if (byte_in < 8'h20) begin
						mode_d       = MODE_IDLE;
						burst.res[0] = jsu_pkg::mk_status(jsu_pkg::ST_CONTROL, here);
						n            = 3'd1;
					end else if (byte_in == "\\") begin
						mode_d = MODE_ESC;
					end else begin
						burst.res[0] = jsu_pkg::mk_data(byte_in);
						n            = 3'd1;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_STR;
					n      = 3'd1;
					unique case (byte_in)
						"\"":    burst.res[0] = jsu_pkg::mk_data(8'h22);
						"\\":    burst.res[0] = jsu_pkg::mk_data(8'h5C);
						"/":     burst.res[0] = jsu_pkg::mk_data(8'h2F);
						"b":     burst.res[0] = jsu_pkg::mk_data(8'h08);
						"f":     burst.res[0] = jsu_pkg::mk_data(8'h0C);
						"n":     burst.res[0] = jsu_pkg::mk_data(8'h0A);
						"r":     burst.res[0] = jsu_pkg::mk_data(8'h0D);
						"t":     burst.res[0] = jsu_pkg::mk_data(8'h09);
						"u": begin
							mode_d    = MODE_HEX;
							hex_cnt_d = 2'd0;
							acc_d     = 16'd0;
							n         = 3'd0;
						end
						default: begin
							mode_d       = MODE_IDLE;
							burst.res[0] = jsu_pkg::mk_status(jsu_pkg::ST_BAD_ESC, here);
						end
					endcase
				end
				MODE_HEX: begin
					if (!hv[4]) begin
						mode_d       = MODE_IDLE;
						burst.res[0] = jsu_pkg::mk_status(jsu_pkg::ST_BAD_HEX, here);
						n            = 3'd1;
					end else begin
						cp    = {acc_q[11:0], hv[3:0]};
						acc_d = cp;
						if (hex_cnt_q == 2'd3) begin
							hex_cnt_d = 2'd0;
							mode_d    = MODE_STR;
							if (cp <= 16'h007F) begin
								burst.res[0] = jsu_pkg::mk_data(cp[7:0]);
								n            = 3'd1;
							end else if (cp <= 16'h07FF) begin
								burst.res[0] = jsu_pkg::mk_data(8'hC0 | {3'd0, cp[10:6]});
								burst.res[1] = jsu_pkg::mk_data(8'h80 | {2'd0, cp[5:0]});
								n            = 3'd2;
							end else begin
								burst.res[0] = jsu_pkg::mk_data(8'hE0 | {4'd0, cp[15:12]});
								burst.res[1] = jsu_pkg::mk_data(8'h80 | {2'd0, cp[11:6]});
								burst.res[2] = jsu_pkg::mk_data(8'h80 | {2'd0, cp[5:0]});
								n            = 3'd3;
							end
						end else begin
							hex_cnt_d = hex_cnt_q + 2'd1;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end

		// end of input inside a string: append the truncation status
		if (input_ends && mode_d != MODE_IDLE && (first_byte || mode_q != MODE_IDLE)) begin
			if (mode_d == MODE_ESC)      trunc_st = jsu_pkg::ST_TRUNC_ESC;
			else if (mode_d == MODE_HEX) trunc_st = jsu_pkg::ST_TRUNC_UNI;
			else                         trunc_st = jsu_pkg::ST_UNTERM;
			burst.res[n[1:0]] = jsu_pkg::mk_status(trunc_st, pos_d);
			mode_d = MODE_IDLE;
			n      = n + 3'd1;
		end
		burst.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'd0;
			pos_q     <= 16'd0;
		end else if (load) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
			pos_q     <= pos_d;
		end
	end

endmodule

// ===== rtl/jsu_burst.sv =====
`timescale 1ns / 1ps
// Result register: holds the results of one byte and sends them one per cycle while result_ready is high.
module jsu_burst (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::burst_t  burst,
	output logic             free,
	output logic             result_valid,
	input  logic             result_ready,
	output logic             kind,
	output logic [7:0]       data_byte,
	output logic [2:0]       status,
	output logic [15:0]      error_position,
	output logic             run_last
);

	jsu_pkg::result_t [jsu_pkg::MAX_RESULTS-1:0] res_q;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic       last;

	assign result_valid   = cnt_q != 3'd0;
	assign last           = ({1'b0, idx_q} + 3'd1) == cnt_q;
	assign free           = !result_valid || (result_ready && last);
	assign run_last       = last;
	assign kind           = res_q[idx_q].kind;
	assign data_byte      = res_q[idx_q].data_byte;
	assign status         = res_q[idx_q].status;
	assign error_position = res_q[idx_q].error_position;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= burst.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= burst.count;
			idx_q <= 2'd0;
		end else if (result_valid && result_ready) begin
			if (last) begin
				cnt_q <= 3'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string unescaper.
//
// Input channel (item_valid/item_ready): one text byte per request, with
// first_byte marking the opening quote and input_ends the last byte on hand.
// Output channel (result_valid/result_ready): one result per request, either a
// decoded byte (kind 0) or a terminal status (kind 1) with its byte offset;
// run_last marks the last result caused by one input byte.
// Results of a byte appear in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte that gives more results holds the input
// while the single result register drains one entry per ready cycle. A byte
// is accepted in the same cycle the last pending result is taken.
// Bytes that give no result (backslash, the u and first three hex digits of
// an escape, bytes after the end) leave the result register empty.
// Reset clears the decoder to waiting for a start byte at offset zero and
// empties the result register. When the receiver stalls, the current result
// holds and the input is backpressured once the register is full.
module json_string_unescape (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  byte_in,
	input  logic        first_byte,
	input  logic        input_ends,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic [15:0] error_position,
	output logic        run_last
);

	jsu_pkg::burst_t burst;
	logic            free;
	logic            load;

	assign item_ready = free;
	assign load       = item_valid && free;

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.byte_in    (byte_in),
		.first_byte (first_byte),
		.input_ends (input_ends),
		.burst      (burst)
	);

	jsu_burst u_burst (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.burst          (burst),
		.free           (free),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.status         (status),
		.error_position (error_position),
		.run_last       (run_last)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape: scoreboard class plus stimulus tasks.

localparam logic [7:0] CH_QUOTE  = 8'h22;
localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_SLASH  = 8'h2F;
localparam logic [7:0] CH_U      = 8'h75;
localparam logic [7:0] CH_B      = 8'h62;
localparam logic [7:0] CH_F      = 8'h66;
localparam logic [7:0] CH_N      = 8'h6E;
localparam logic [7:0] CH_R      = 8'h72;
localparam logic [7:0] CH_T      = 8'h74;

typedef enum logic [1:0] {SCAN_IDLE, SCAN_STR, SCAN_ESC, SCAN_HEX} scan_mode_t;

typedef struct packed {
	logic        kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [15:0] error_position;
	logic        run_last;
} decoded_t;

class unescape_scoreboard;
	scan_mode_t  mode;
	logic [1:0]  hex_count;
	logic [15:0] code_point;
	logic [15:0] offset;
	decoded_t    decoded_q[$];
	decoded_t    burst[$];
	int          errors;

	function new();
		mode = SCAN_IDLE;
		hex_count = 2'd0;
		code_point = 16'd0;
		offset = 16'd0;
		errors = 0;
	endfunction

	function void add_data(logic [7:0] d);
		decoded_t r;
		r = '{jsu_pkg::KIND_DATA, d, jsu_pkg::ST_OK, 16'd0, 1'b0};
		burst = {burst, r};
	endfunction

	function void add_status(logic [2:0] s, logic [15:0] p);
		decoded_t r;
		r = '{jsu_pkg::KIND_STATUS, 8'd0, s, p, 1'b0};
		burst = {burst, r};
	endfunction

	function logic [15:0] bump(logic [15:0] p);
		return (p >= jsu_pkg::POS_LIMIT) ? jsu_pkg::POS_LIMIT : p + 16'd1;
	endfunction

	function int hex_value(logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
		if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
		if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
		return -1;
	endfunction

	// Returns 0 when the byte is ignored (idle, no start flag).
	function bit decode_byte(logic [7:0] b, logic f, logic e);
		logic [15:0] here;
		int v;
		burst.delete();
		if (f) begin
			hex_count = 2'd0;
			code_point = 16'd0;
			here = 16'd0;
			offset = bump(16'd0);
			if (b != CH_QUOTE) begin
				mode = SCAN_IDLE;
				add_status(jsu_pkg::ST_NO_QUOTE, here);
			end else begin
				mode = SCAN_STR;
			end
		end else begin
			if (mode == SCAN_IDLE)
				return 1'b0;
			here = offset;
			offset = bump(here);
			case (mode)
			SCAN_STR: begin
				if (b == CH_QUOTE) begin
					mode = SCAN_IDLE;
					add_status(jsu_pkg::ST_OK, 16'd0);
				end else if (b < 8'h20) begin
					mode = SCAN_IDLE;
					add_status(jsu_pkg::ST_CONTROL, here);
				end else if (b == CH_BSLASH) begin
					mode = SCAN_ESC;
				end else begin
					add_data(b);
				end
			end
			SCAN_ESC: begin
				mode = SCAN_STR;
				case (b)
				CH_QUOTE, CH_BSLASH, CH_SLASH: add_data(b);
				CH_B: add_data(8'h08);
				CH_F: add_data(8'h0C);
				CH_N: add_data(8'h0A);
				CH_R: add_data(8'h0D);
				CH_T: add_data(8'h09);
				CH_U: begin
					mode = SCAN_HEX;
					hex_count = 2'd0;
					code_point = 16'd0;
				end
				default: begin
					mode = SCAN_IDLE;
					add_status(jsu_pkg::ST_BAD_ESC, here);
				end
				endcase
			end
			default: begin
				v = hex_value(b);
				if (v < 0) begin
					mode = SCAN_IDLE;
					add_status(jsu_pkg::ST_BAD_HEX, here);
				end else begin
					code_point = {code_point[11:0], 4'(v)};
					if (hex_count == 2'd3) begin
						hex_count = 2'd0;
						mode = SCAN_STR;
						if (code_point <= 16'h007F) begin
							add_data(code_point[7:0]);
						end else if (code_point <= 16'h07FF) begin
							add_data({3'b110, code_point[10:6]});
							add_data({2'b10, code_point[5:0]});
						end else begin
							add_data({4'b1110, code_point[15:12]});
							add_data({2'b10, code_point[11:6]});
							add_data({2'b10, code_point[5:0]});
						end
					end else begin
						hex_count = hex_count + 2'd1;
					end
				end
			end
			endcase
		end
		if (e && mode != SCAN_IDLE) begin
			add_status(mode == SCAN_STR ? jsu_pkg::ST_UNTERM :
				(mode == SCAN_ESC ? jsu_pkg::ST_TRUNC_ESC : jsu_pkg::ST_TRUNC_UNI), offset);
			mode = SCAN_IDLE;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].run_last = 1'b1;
		foreach (burst[i])
			decoded_q = {decoded_q, burst[i]};
		return 1'b1;
	endfunction

	function void check_result(decoded_t got);
		decoded_t want;
		if (decoded_q.size() == 0) begin
			errors++;
			$error("unexpected result: kind %0d data %02h status %0d position %0d last %0d",
				got.kind, got.data_byte, got.status, got.error_position, got.run_last);
			return;
		end
		want = decoded_q.pop_front();
		if (got.kind !== want.kind) begin
			errors++;
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
		end
		if (got.data_byte !== want.data_byte) begin
			errors++;
			$error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
		end
		if (got.status !== want.status) begin
			errors++;
			$error("status: expected %0d, got %0d", want.status, got.status);
		end
		if (got.error_position !== want.error_position) begin
			errors++;
			$error("error_position: expected %0d, got %0d", want.error_position,
				got.error_position);
		end
		if (got.run_last !== want.run_last) begin
			errors++;
			$error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
		end
	endfunction
endclass

module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_REQUESTS = 135;
	localparam logic [63:0] ESCAPES = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [7:0]  byte_in;
	logic        first_byte;
	logic        input_ends;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [15:0] error_position;
	logic        run_last;

	bit                 calm = 1'b0;
	int                 cycles = 0;
	int                 taken = 0;
	logic [7:0]         text_q[$];
	unescape_scoreboard board;

	json_string_unescape u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.byte_in        (byte_in),
		.first_byte     (first_byte),
		.input_ends     (input_ends),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.status         (status),
		.error_position (error_position),
		.run_last       (run_last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 21);
	endfunction

	always @(negedge clk) begin
		result_ready = !take_break();
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_result('{kind, data_byte, status, error_position, run_last});
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	function automatic bit is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic bit is_escape(logic [7:0] c);
		bit hit;
		hit = (c == CH_U);
		for (int i = 0; i < 8; i++)
			if (ESCAPES[8*i +: 8] == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [7:0] raw_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h20, 8'hFF));
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [15:0] random_code_point();
		case ($urandom_range(0, 2))
		0: return 16'($urandom_range(0, 16'h007F));
		1: return 16'($urandom_range(16'h0080, 16'h07FF));
		default: return 16'($urandom_range(16'h0800, 16'hFFFF));
		endcase
	endfunction

	// Leading n hex digits of cp, in mixed case.
	function automatic void push_hex(logic [15:0] cp, int n);
		logic [3:0] nib;
		for (int i = 3; i > 3 - n; i--) begin
			nib = cp[4*i +: 4];
			if (nib < 4'd10)
				text_q = {text_q, 8'(8'h30 + nib)};
			else
				text_q = {text_q,
					8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10)};
		end
	endfunction

	function automatic void push_token();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: text_q = {text_q, raw_byte()};
		6, 7: begin
			text_q = {text_q, CH_BSLASH};
			text_q = {text_q, ESCAPES[8*$urandom_range(0, 7) +: 8]};
		end
		default: begin
			text_q = {text_q, CH_BSLASH};
			text_q = {text_q, CH_U};
			push_hex(random_code_point(), 4);
		end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic f, input logic e);
		while (take_break())
			@(negedge clk);
		item_valid = 1'b1;
		byte_in = b;
		first_byte = f;
		input_ends = e;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		void'(board.decode_byte(b, f, e));
		taken++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic send_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == 0, ends && i == s.len() - 1);
	endtask

	task automatic send_queue(input bit ends);
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == 0, ends && i == text_q.size() - 1);
	endtask

	task automatic send_string();
		bit ends;
		logic [7:0] c;
		text_q.delete();
		text_q = {text_q, CH_QUOTE};
		ends = 1'b0;
		repeat ($urandom_range(0, 8))
			push_token();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: begin
			text_q = {text_q, CH_QUOTE};
			ends = ($urandom_range(0, 3) == 0);
		end
		5: text_q = {text_q, 8'($urandom_range(0, 8'h1F))};
		6: begin
			do
				c = 8'($urandom_range(0, 255));
			while (is_escape(c));
			text_q = {text_q, CH_BSLASH};
			text_q = {text_q, c};
		end
		7: begin
			do
				c = 8'($urandom_range(0, 255));
			while (is_hex(c));
			text_q = {text_q, CH_BSLASH};
			text_q = {text_q, CH_U};
			push_hex(random_code_point(), $urandom_range(0, 3));
			text_q = {text_q, c};
		end
		8: begin
			case ($urandom_range(0, 2))
			0: ;
			1: text_q = {text_q, CH_BSLASH};
			default: begin
				text_q = {text_q, CH_BSLASH};
				text_q = {text_q, CH_U};
				push_hex(random_code_point(), $urandom_range(0, 3));
			end
			endcase
			ends = 1'b1;
		end
		default: ; // left open: the next start byte restarts it
		endcase
		send_queue(ends);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		byte_in = 8'd0;
		first_byte = 1'b0;
		input_ends = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text("x", 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h1F, 1'b0, 1'b0);
		send_text("\"\\uFFFF", 1'b1);
		send_text("\"\\q", 1'b0);
		send_text("\"\\u0G", 1'b0);
		send_text("\"\\", 1'b1);
		send_text("\"\\u1", 1'b1);
		send_text("\"a", 1'b0);
		send_text("\"\\/\"", 1'b0);
		send_text("\"", 1'b1);

		taken = 0;
		while (taken < RANDOM_REQUESTS) begin
			calm = (taken >= 60 && taken < 110);
			if ($urandom_range(0, 99) < 12)
				send_noise();
			else
				send_string();
		end
		calm = 1'b0;

		while (board.decoded_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
